FILE: hw/rtl/ttlc_pkg.sv
// Shared types and constants for the TTL lookup table.
`default_nettype none
package ttlc_pkg;
  localparam int Capacity = 256;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int CfgDataW = 32;
  localparam int CfgIdxW = 1;

  localparam logic [2:0] CmdLookup = 3'd0;
  localparam logic [2:0] CmdStore = 3'd1;
  localparam logic [2:0] CmdInval = 3'd2;
  localparam logic [2:0] CmdClear = 3'd3;
  localparam logic [2:0] CmdPrune = 3'd4;

  localparam logic [CfgIdxW-1:0] RegEntryLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegAgeLimit = 1'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] file_hash;
    logic [31:0] line_hash;
    logic [31:0] cursor_pos;
    logic [31:0] language_hash;
    logic [31:0] payload;
    logic [31:0] now_ms;
  } item_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_payload;
    logic [15:0] entry_hits;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [8:0]  occupancy;
  } item_out_t;

  // Per-slot record kept in the slot memory.
  typedef struct packed {
    logic [63:0] file_hash;
    logic [31:0] line_hash;
    logic [31:0] cursor_pos;
    logic [31:0] language_hash;
    logic [31:0] payload;
    logic [31:0] stamp;
    logic [15:0] hits;
  } slot_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ttl_cache_oldest_eviction_core.sv
// Top level of the TTL lookup table with oldest-first eviction.
`default_nettype none
// A command item is taken when start is high and busy is low. Busy then stays
// high until the item's one result is ready. The result is shown for a single
// cycle with done high, in the first cycle with busy low, and a new item may
// be taken in that same cycle. The receiver cannot stall results, so sample
// item_out whenever done is high. Lookup, invalidate, prune and store items
// walk the slot memory one slot per cycle through a single read port and a
// single age/key compare unit; clear and the unused commands do not walk it.
// A store that needs eviction runs one eviction sweep plus one drop step for
// each evicted entry before its key sweep, so a store after the entry limit
// was lowered below the occupancy can run for many sweeps. Slot valid bits live
// in flip-flops cleared by reset, so no clearing pass is needed after reset.
module ttl_cache_oldest_eviction_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ttlc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ttlc_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          start,
  input  wire ttlc_pkg::item_in_t            item_in,
  output logic                               busy,
  output logic                               done,
  output ttlc_pkg::item_out_t                item_out
);
  import ttlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EVICT, ST_DROP, ST_FINISH, ST_WRITE, ST_RESULT
  } state_t;

  state_t              state;
  item_in_t            cur;
  logic [8:0]          entry_limit;
  logic [31:0]         age_limit;
  logic [Capacity-1:0] valid;
  logic [CountW-1:0]   valid_count;
  logic [31:0]         hit_counter, miss_counter;
  // Scan address counter, one wider to catch the end of the sweep.
  logic [SlotW:0]      addr;
  logic [SlotW-1:0]    rd_slot;
  logic                rd_live;
  logic                found;
  logic [SlotW-1:0]    pick;
  logic [31:0]         best_age;
  logic [CountW-1:0]   lim;
  logic                res_hit;
  logic [31:0]         res_payload;
  logic [15:0]         res_hits;

  logic                ram_we;
  logic [SlotW-1:0]    ram_waddr;
  slot_t               ram_wdata, ram_rdata;

  ttlc_slot_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(addr[SlotW-1:0]), .rdata(ram_rdata)
  );

  // Shared compare unit over the slot read in the previous cycle.
  logic [31:0] rd_age;
  logic        key_eq, expired;
  assign rd_age  = cur.now_ms - ram_rdata.stamp;
  assign expired = rd_age > age_limit;
  assign key_eq  = rd_live && ram_rdata.file_hash == cur.file_hash &&
                   ram_rdata.line_hash == cur.line_hash &&
                   ram_rdata.cursor_pos == cur.cursor_pos &&
                   ram_rdata.language_hash == cur.language_hash;

  // Effective limit clamped to 1..Capacity.
  always_comb begin
    if (entry_limit == 9'd0) begin
      lim = CountW'(1);
    end else if (32'(entry_limit) > Capacity) begin
      lim = CountW'(Capacity);
    end else begin
      lim = CountW'(entry_limit);
    end
  end

  // Sweep control: a store skips the eviction sweep when there is room, a
  // read is issued for each address, and the sweep ends once the last read
  // has been compared.
  logic sweep, skip_evict, issue, sweep_end;
  assign sweep      = (state == ST_SCAN) || (state == ST_EVICT);
  assign skip_evict = (state == ST_EVICT) && addr == '0 && !rd_live && !found &&
                      valid_count < lim;
  assign issue      = sweep && !skip_evict && !addr[SlotW];
  assign sweep_end  = sweep && !skip_evict && addr[SlotW] && !rd_live;

  // Lowest free slot.
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  logic [15:0] hits_inc;
  assign hits_inc = (ram_rdata.hits == 16'hFFFF) ? ram_rdata.hits : ram_rdata.hits + 16'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = ram_rdata;
    if (state == ST_SCAN && key_eq && !found && cur.cmd == CmdLookup && !expired) begin
      ram_we          = 1'b1;
      ram_waddr       = rd_slot;
      ram_wdata.hits  = hits_inc;
    end else if (state == ST_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = found ? pick : free_slot;
      ram_wdata = '{file_hash: cur.file_hash, line_hash: cur.line_hash,
                    cursor_pos: cur.cursor_pos, language_hash: cur.language_hash,
                    payload: cur.payload, stamp: cur.now_ms, hits: 16'd0};
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_limit  <= 9'd256;
      age_limit    <= 32'd30000;
      valid        <= '0;
      valid_count  <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      done         <= 1'b0;
      rd_live      <= 1'b0;
      res_hit      <= 1'b0;
      res_payload  <= '0;
      res_hits     <= '0;
    end else begin
      // Strobe the result in the cycle after the result state.
      done <= (state == ST_RESULT);
      if (cfg_we) begin
        unique case (cfg_index)
          RegEntryLimit: entry_limit <= cfg_data[8:0];
          RegAgeLimit:   age_limit   <= cfg_data;
          default: ;
        endcase
      end
      rd_slot <= addr[SlotW-1:0];
      rd_live <= issue ? valid[addr[SlotW-1:0]] : 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur         <= item_in;
            addr        <= '0;
            found       <= 1'b0;
            res_hit     <= 1'b0;
            res_payload <= '0;
            res_hits    <= '0;
            unique case (item_in.cmd)
              CmdLookup, CmdInval, CmdPrune: state <= ST_SCAN;
              CmdStore:                      state <= ST_EVICT;
              CmdClear: begin
                valid       <= '0;
                valid_count <= '0;
                state       <= ST_RESULT;
              end
              default: state <= ST_RESULT;
            endcase
          end
        end
        // Walk every slot; compare the slot read last cycle.
        ST_SCAN, ST_EVICT: begin
          if (skip_evict) begin
            // Room available: go look for the key.
            state <= ST_SCAN;
          end else begin
            if (issue) begin
              addr <= addr + (SlotW + 1)'(1);
            end
            if (rd_live) begin
              if (state == ST_EVICT) begin
                if (!found || rd_age > best_age) begin
                  found    <= 1'b1;
                  pick     <= rd_slot;
                  best_age <= rd_age;
                end
              end else if (cur.cmd == CmdPrune) begin
                if (expired) begin
                  valid[rd_slot] <= 1'b0;
                  valid_count    <= valid_count - CountW'(1);
                end
              end else if (key_eq && !found) begin
                found <= 1'b1;
                pick  <= rd_slot;
                if (cur.cmd == CmdInval) begin
                  valid[rd_slot] <= 1'b0;
                  valid_count    <= valid_count - CountW'(1);
                end else if (cur.cmd == CmdLookup) begin
                  if (expired) begin
                    valid[rd_slot] <= 1'b0;
                    valid_count    <= valid_count - CountW'(1);
                  end else begin
                    res_hit     <= 1'b1;
                    res_payload <= ram_rdata.payload;
                    res_hits    <= hits_inc;
                  end
                end
              end
            end
            if (sweep_end) begin
              state <= (state == ST_EVICT) ? ST_DROP : ST_FINISH;
            end
          end
        end
        // Drop the oldest, then check the limit again.
        ST_DROP: begin
          valid[pick] <= 1'b0;
          valid_count <= valid_count - CountW'(1);
          addr        <= '0;
          found       <= 1'b0;
          state       <= ST_EVICT;
        end
        ST_FINISH: begin
          priority if (cur.cmd == CmdLookup) begin
            if (res_hit) begin
              hit_counter <= hit_counter + 32'd1;
            end else begin
              miss_counter <= miss_counter + 32'd1;
            end
            state <= ST_RESULT;
          end else if (cur.cmd == CmdStore) begin
            // Hold found and pick: they name the slot to overwrite.
            state <= ST_WRITE;
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_WRITE: begin
          if (!found) begin
            valid[free_slot] <= 1'b1;
            valid_count      <= valid_count + CountW'(1);
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    item_out.hit          = res_hit;
    item_out.read_payload = res_payload;
    item_out.entry_hits   = res_hits;
    item_out.total_hits   = hit_counter;
    item_out.total_misses = miss_counter;
    item_out.occupancy    = 9'(valid_count);
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CountW'(Capacity)) else $error("occupancy over capacity");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held longer than one cycle");
  a_idle_done: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE) else $error("result while busy");
endmodule
`default_nettype wire

FILE: hw/rtl/ttlc_slot_ram.sv
// Slot record memory: one write port, one registered read port.
`default_nettype none
module ttlc_slot_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ttlc_pkg::SlotW-1:0] waddr,
  input  wire ttlc_pkg::slot_t       wdata,
  input  wire logic [ttlc_pkg::SlotW-1:0] raddr,
  output ttlc_pkg::slot_t            rdata
);
  import ttlc_pkg::*;
  slot_t mem [Capacity];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/tb_ttl_cache_oldest_eviction_core.sv
// Self-checking testbench for the TTL lookup table with oldest-first eviction.
`default_nettype none
module tb_ttl_cache_oldest_eviction_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ttlc_pkg::*;

  localparam int NumPool = 48;
  localparam int NumRecent = 32;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                start = 1'b0;
  item_in_t            item_in = '0;
  logic                busy;
  logic                done;
  item_out_t           item_out;

  ttl_cache_oldest_eviction_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .start    (start),
    .item_in  (item_in),
    .busy     (busy),
    .done     (done),
    .item_out (item_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the table, its totals and its two registers.
  logic [8:0]  shadow_limit;
  logic [31:0] shadow_age_limit;
  logic        tbl_valid [Capacity];
  slot_t       tbl_slot [Capacity];
  logic [31:0] tbl_hit_total;
  logic [31:0] tbl_miss_total;
  logic [8:0]  tbl_count;

  item_out_t   pending_results[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          peak_count = 0;
  int          idle_pct = 0;

  item_in_t    key_pool [NumPool];
  item_in_t    recent_keys [NumRecent];
  int          recent_fill = 0;
  int          recent_ptr = 0;
  logic [31:0] clock_ms = 0;

  function automatic bit same_key(slot_t s, item_in_t it);
    return s.file_hash == it.file_hash && s.line_hash == it.line_hash &&
           s.cursor_pos == it.cursor_pos && s.language_hash == it.language_hash;
  endfunction

  function automatic int find_slot(item_in_t it);
    for (int i = 0; i < Capacity; i++) begin
      if (tbl_valid[i] && same_key(tbl_slot[i], it)) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    if (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_count--;
    end
  endfunction

  // Drop the entry with the greatest wrapped age; the lowest slot wins a tie.
  function automatic void evict_oldest(logic [31:0] now);
    int          pick;
    logic [31:0] best;
    logic [31:0] age;
    pick = -1;
    best = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (tbl_valid[i]) begin
        age = now - tbl_slot[i].stamp;
        if (pick < 0 || age > best) begin
          pick = i;
          best = age;
        end
      end
    end
    if (pick >= 0) drop_slot(pick);
  endfunction

  // Apply one command to the shadow table and return the result it yields.
  function automatic item_out_t predict_lookup_result(item_in_t it);
    item_out_t   res;
    int          s;
    logic [8:0]  lim;
    res = '0;
    case (it.cmd)
      CmdLookup: begin
        s = find_slot(it);
        if (s < 0) begin
          tbl_miss_total++;
        end else if (it.now_ms - tbl_slot[s].stamp > shadow_age_limit) begin
          drop_slot(s);
          tbl_miss_total++;
        end else begin
          if (tbl_slot[s].hits != 16'hFFFF) tbl_slot[s].hits++;
          tbl_hit_total++;
          res.hit = 1'b1;
          res.read_payload = tbl_slot[s].payload;
          res.entry_hits = tbl_slot[s].hits;
        end
      end
      CmdStore: begin
        lim = shadow_limit;
        if (lim == 0) lim = 9'd1;
        if (lim > Capacity) lim = 9'(Capacity);
        while (tbl_count >= lim) evict_oldest(it.now_ms);
        s = find_slot(it);
        if (s < 0) begin
          for (s = 0; s < Capacity && tbl_valid[s]; s++) begin
          end
          tbl_valid[s] = 1'b1;
          tbl_count++;
        end
        tbl_slot[s] = '{it.file_hash, it.line_hash, it.cursor_pos, it.language_hash,
                        it.payload, it.now_ms, 16'd0};
      end
      CmdInval: begin
        s = find_slot(it);
        if (s >= 0) drop_slot(s);
      end
      CmdClear: begin
        for (int i = 0; i < Capacity; i++) tbl_valid[i] = 1'b0;
        tbl_count = '0;
      end
      CmdPrune: begin
        for (int i = 0; i < Capacity; i++) begin
          if (tbl_valid[i] && it.now_ms - tbl_slot[i].stamp > shadow_age_limit) drop_slot(i);
        end
      end
      default: ;
    endcase
    res.total_hits = tbl_hit_total;
    res.total_misses = tbl_miss_total;
    res.occupancy = tbl_count;
    if (tbl_count > peak_count) peak_count = tbl_count;
    return res;
  endfunction

  // Compare every strobed result with the oldest expectation; done is sampled
  // before the block's own updates of this edge land.
  always @(posedge clk) begin
    item_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (item_out.hit) hits_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", item_out);
      end else begin
        want = pending_results.pop_front();
        if (item_out.hit !== want.hit || item_out.read_payload !== want.read_payload ||
            item_out.entry_hits !== want.entry_hits ||
            item_out.total_hits !== want.total_hits ||
            item_out.total_misses !== want.total_misses ||
            item_out.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d differs: expected %p", results_seen, want);
            $display("                     actual %p", item_out);
          end
        end
      end
    end
  end

  // Hold the item on the port until the block takes it, then log what it
  // should produce. Enter and leave right after a rising edge.
  task automatic send_item(item_in_t it, bit typed, item_out_t typed_res);
    item_out_t res;
    start <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (busy);
    res = predict_lookup_result(it);
    pending_results = {pending_results, typed ? typed_res : res};
    items_sent++;
    // Drop start for a while now and then; a long gap reaches into later
    // phases of the next item's sweep window.
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 300) : $urandom_range(1, 4))
        @(posedge clk);
    end
  endtask

  // Wait until every expected result is back and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_registers(logic [31:0] limit_word, logic [31:0] age_word);
    cfg_we <= 1'b1;
    cfg_index <= RegEntryLimit;
    cfg_data <= limit_word;
    @(posedge clk);
    cfg_index <= RegAgeLimit;
    cfg_data <= age_word;
    shadow_limit = limit_word[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_age_limit = age_word;
  endtask

  function automatic item_in_t random_key();
    item_in_t k;
    k = '0;
    k.file_hash = {$urandom, $urandom};
    k.line_hash = $urandom;
    k.cursor_pos = $urandom;
    k.language_hash = $urandom;
    return k;
  endfunction

  // Pick a key: mostly one stored lately, else pool, fresh, or one bit off.
  function automatic item_in_t pick_key();
    item_in_t k;
    int       r;
    r = $urandom_range(0, 99);
    if (recent_fill == 0 || r >= 95) k = random_key();
    else if (r < 70) k = recent_keys[$urandom_range(0, recent_fill - 1)];
    else if (r < 85) k = key_pool[$urandom_range(0, NumPool - 1)];
    else begin
      k = recent_keys[$urandom_range(0, recent_fill - 1)];
      case ($urandom_range(0, 3))
        0: k.file_hash[$urandom_range(0, 63)] ^= 1'b1;
        1: k.line_hash[$urandom_range(0, 31)] ^= 1'b1;
        2: k.cursor_pos[$urandom_range(0, 31)] ^= 1'b1;
        default: k.language_hash[$urandom_range(0, 31)] ^= 1'b1;
      endcase
    end
    return k;
  endfunction

  function automatic item_in_t random_item(int store_pct, int fresh_pct, int step);
    item_in_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < store_pct && $urandom_range(0, 99) < fresh_pct) it = random_key();
    else it = pick_key();
    if (r < store_pct) it.cmd = CmdStore;
    else if (r < store_pct + 8) it.cmd = CmdInval;
    else if (r < store_pct + 12) it.cmd = CmdPrune;
    else if (r < store_pct + 13) it.cmd = CmdClear;
    else if (r < store_pct + 16) it.cmd = 3'($urandom_range(5, 7));
    else it.cmd = CmdLookup;
    // Advance the clock; now and then jump anywhere, backward included.
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, step);
    it.now_ms = clock_ms;
    it.payload = $urandom;
    if (it.cmd == CmdStore) begin
      recent_keys[recent_ptr] = it;
      recent_ptr = (recent_ptr + 1) % NumRecent;
      if (recent_fill < NumRecent) recent_fill++;
    end
    return it;
  endfunction

  typedef struct {
    item_in_t  it;
    bit        typed;
    item_out_t res;
  } stim_row_t;

  typedef struct {
    logic [31:0] limit_word;
    logic [31:0] age_word;
    int          count;
    int          store_pct;
    int          fresh_pct;
    int          step;
    int          idle;
  } phase_t;

  function automatic stim_row_t mk_row(logic [2:0] cmd, item_in_t key, logic [31:0] pl,
                                       logic [31:0] now, bit typed, item_out_t res);
    stim_row_t row;
    row.it = key;
    row.it.cmd = cmd;
    row.it.payload = pl;
    row.it.now_ms = now;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  initial begin
    stim_row_t  rows[$];
    phase_t     phases[$];
    item_in_t   key_a;
    item_in_t   key_b;
    item_in_t   key_c;
    item_out_t  none;

    tbl_hit_total = '0;
    tbl_miss_total = '0;
    tbl_count = '0;
    shadow_limit = 9'd256;
    shadow_age_limit = 32'd30000;
    for (int i = 0; i < Capacity; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < NumPool; i++) key_pool[i] = random_key();

    // Hold reset, then release it for good.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: reset-default registers, all-zero and all-one keys, a key
    // that differs only in its language part, the age boundary, refresh of a
    // present key, wrapped ages, prune, clear and the unused commands.
    key_a = '0;
    key_b = '1;
    key_c = key_b;
    key_c.language_hash = '0;
    none = '0;
    rows = {rows, mk_row(CmdLookup, key_a, 0, 0, 1, '{0, 0, 0, 0, 1, 0})};
    rows = {rows, mk_row(CmdStore, key_a, 32'hFFFF_FFFF, 100, 1, '{0, 0, 0, 0, 1, 1})};
    rows = {rows, mk_row(CmdLookup, key_a, 0, 100, 1,
                         '{1, 32'hFFFF_FFFF, 1, 1, 1, 1})};
    rows = {rows, mk_row(CmdStore, key_b, 0, 200, 1, '{0, 0, 0, 1, 1, 2})};
    rows = {rows, mk_row(CmdLookup, key_c, 0, 200, 1, '{0, 0, 0, 1, 2, 2})};
    // Age equal to the limit still hits; one past it expires and drops.
    rows = {rows, mk_row(CmdLookup, key_a, 0, 30100, 1,
                         '{1, 32'hFFFF_FFFF, 2, 2, 2, 2})};
    rows = {rows, mk_row(CmdLookup, key_a, 0, 30101, 1, '{0, 0, 0, 2, 3, 1})};
    rows = {rows, mk_row(CmdStore, key_b, 32'h1234, 300, 0, none)};
    rows = {rows, mk_row(CmdLookup, key_b, 0, 300, 0, none)};
    rows = {rows, mk_row(CmdInval, key_b, 0, 0, 1, '{0, 0, 0, 3, 3, 0})};
    rows = {rows, mk_row(CmdStore, key_a, 5, 32'hFFFF_FF00, 0, none)};
    rows = {rows, mk_row(CmdStore, key_b, 6, 32'h10, 0, none)};
    rows = {rows, mk_row(CmdLookup, key_a, 0, 32'h20, 0, none)};
    rows = {rows, mk_row(CmdPrune, key_a, 0, 32'h8000_0000, 1, '{0, 0, 0, 4, 3, 0})};
    rows = {rows, mk_row(CmdStore, key_a, 7, 0, 0, none)};
    rows = {rows, mk_row(CmdClear, key_a, 0, 0, 1, '{0, 0, 0, 4, 3, 0})};
    rows = {rows, mk_row(3'd5, key_a, 0, 0, 1, '{0, 0, 0, 4, 3, 0})};
    rows = {rows, mk_row(3'd6, key_b, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{0, 0, 0, 4, 3, 0})};
    rows = {rows, mk_row(3'd7, key_b, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{0, 0, 0, 4, 3, 0})};
    idle_pct = 29;
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    // Random part: fill the full table, then shrink the limit, sweep the age
    // limit across its extremes and mask off high bits of the limit word.
    phases = {phases, phase_t'{32'd256, 32'hFFFF_FFFF, 380, 70, 80, 10, 29}};
    phases = {phases, phase_t'{32'hFFFF_FE03, 32'd1000, 170, 35, 20, 200, 29}};
    phases = {phases, phase_t'{32'd0, 32'd0, 110, 40, 30, 1, 75}};
    phases = {phases, phase_t'{32'd511, 32'd30000, 170, 40, 30, 3000, 75}};
    phases = {phases, phase_t'{32'd16, 32'd5000, 230, 40, 40, 300, 0}};
    phases = {phases, phase_t'{32'd1, 32'd500, 190, 45, 30, 200, 0}};
    foreach (phases[p]) begin
      wait_drained();
      write_registers(phases[p].limit_word, phases[p].age_word);
      idle_pct = phases[p].idle;
      repeat (phases[p].count)
        send_item(random_item(phases[p].store_pct, phases[p].fresh_pct, phases[p].step),
                  0, none);
    end

    // Drain, then keep the clock running so any stray strobe is still caught.
    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d items over %0d register settings; %0d results, %0d hits",
             items_sent, phases.size(), results_seen, hits_seen);
    $display("peak occupancy %0d, mismatches %0d", peak_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #1_000_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
